// ----- design/jam_pkg.sv -----
// Shared types and constants of the joystick axis mapper.
// Used by jam_front, jam_div_cell and joystick_axis_mapper_unit; no dependencies.
`default_nettype none

package jam_pkg;

    localparam int SAMPLE_BITS_DEF = 12;   // default raw ADC sample width
    localparam int CFG_W           = 12;   // width of the range, deadband and margin fields
    localparam int FS_W            = 15;   // width of full_scale
    localparam int Q_W             = FS_W; // quotient bits, one per divider cell
    localparam int CMD_W           = 16;   // width of the signed command
    localparam int PROD_W          = CFG_W + FS_W;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 15;

    localparam logic [CFG_W-1:0] RST_RANGE_MIN    = 12'd0;
    localparam logic [CFG_W-1:0] RST_RANGE_CENTER = 12'd2048;
    localparam logic [CFG_W-1:0] RST_RANGE_MAX    = 12'd4095;
    localparam logic [CFG_W-1:0] RST_DEAD_WIDTH   = 12'd0;
    localparam logic [CFG_W-1:0] RST_MARGIN       = 12'd0;
    localparam logic [FS_W-1:0]  RST_FULL_SCALE   = 15'd1000;
    localparam logic             RST_REVERSE      = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_MIN    = 3'd0,
        CFG_RANGE_CENTER = 3'd1,
        CFG_RANGE_MAX    = 3'd2,
        CFG_DEAD_WIDTH   = 3'd3,
        CFG_MARGIN       = 3'd4,
        CFG_FULL_SCALE   = 3'd5,
        CFG_REVERSE      = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] range_min;
        logic [CFG_W-1:0] range_center;
        logic [CFG_W-1:0] range_max;
        logic [CFG_W-1:0] dead_width;
        logic [CFG_W-1:0] margin;
        logic [FS_W-1:0]  full_scale;
        logic             reverse;
    } cfg_t;

    // Partial division state handed from cell to cell.
    typedef struct packed {
        logic [CFG_W-1:0] rem;   // partial remainder, always below dvs
        logic [Q_W-1:0]   dvd;   // dividend bits still to shift in, MSB first
        logic [Q_W-1:0]   quo;   // quotient bits produced so far
        logic [CFG_W-1:0] dvs;   // divisor (span of the side taken)
        logic             neg;   // negate the quotient at the end
        logic             dead;  // sample fell inside the deadband
    } div_t;

endpackage

`default_nettype wire

// ----- design/jam_front.sv -----
// Front pipeline: range narrowing, clamp, centering, deadband and scaling product.
// Depends on jam_pkg; feeds the first jam_div_cell.
`default_nettype none

module jam_front #(
    parameter int SAMPLE_BITS = jam_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire jam_pkg::cfg_t          cfg,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    output logic                        dn_valid,
    input  wire logic                   dn_ready,
    output jam_pkg::div_t               dn_data
);
    import jam_pkg::*;

    localparam int CMP_W = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;

    // stage valid bits and load enables
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic ld1, ld2, ld3, ld4;

    // stage 1: sample and effective limits
    logic [SAMPLE_BITS-1:0] s1_smp_reg;
    logic [CFG_W-1:0]       s1_lo_reg, s1_hi_reg;
    logic [CFG_W-1:0]       s1_lo_next, s1_hi_next;
    logic signed [CFG_W+1:0] lo_n, hi_n;

    // stage 2: signed offset from center
    logic signed [CFG_W:0]  s2_off_reg, s2_off_next;
    logic [CFG_W-1:0]       s2_lo_reg, s2_hi_reg;
    logic [CMP_W-1:0]       smp_ext, lo_ext, hi_ext;
    logic [CFG_W-1:0]       clamped;
    logic signed [CFG_W:0]  off_raw;

    // stage 3: deflection past the deadband and span of the side taken
    logic [CFG_W-1:0]       s3_a_reg, s3_span_reg;
    logic                   s3_neg_reg, s3_dead_reg, s3_zero_reg;
    logic signed [CFG_W+1:0] off14, db14, c14, a14, span_p, span_n, span_sel;
    logic                   pos, dead, zero;

    // stage 4: product and initial remainder
    div_t                   s4_reg, s4_next;
    logic [CFG_W-1:0]       a_lim;
    logic [PROD_W-1:0]      prod;

    assign ld4      = !s4_v_reg || dn_ready;
    assign ld3      = !s3_v_reg || ld4;
    assign ld2      = !s2_v_reg || ld3;
    assign ld1      = !s1_v_reg || ld2;
    assign in_ready = ld1;
    assign dn_valid = s4_v_reg;
    assign dn_data  = s4_reg;

    always_comb
    begin
        lo_n = {2'b00, cfg.range_min} + {2'b00, cfg.margin};
        hi_n = {2'b00, cfg.range_max} - {2'b00, cfg.margin};
        if (lo_n < hi_n)
        begin
            s1_lo_next = lo_n[CFG_W-1:0];
            s1_hi_next = hi_n[CFG_W-1:0];
        end
        else
        begin
            // narrowed range empty or a single point: fall back to min..max
            s1_lo_next = cfg.range_min;
            s1_hi_next = cfg.range_max;
        end
    end

    always_comb
    begin
        smp_ext = CMP_W'(s1_smp_reg);
        lo_ext  = CMP_W'(s1_lo_reg);
        hi_ext  = CMP_W'(s1_hi_reg);
        priority if (smp_ext < lo_ext)
            clamped = s1_lo_reg;
        else if (smp_ext > hi_ext)
            clamped = s1_hi_reg;
        else
            clamped = smp_ext[CFG_W-1:0];
        off_raw     = {1'b0, clamped} - {1'b0, cfg.range_center};
        s2_off_next = cfg.reverse ? -off_raw : off_raw;
    end

    always_comb
    begin
        off14  = {s2_off_reg[CFG_W], s2_off_reg};
        db14   = {2'b00, cfg.dead_width};
        c14    = {2'b00, cfg.range_center};
        dead   = (off14 > -db14) && (off14 < db14);
        pos    = off14 > 14'sd0;
        a14    = pos ? (off14 - db14) : (-off14 - db14);
        span_p = {2'b00, s2_hi_reg} - c14 - db14;
        span_n = c14 - {2'b00, s2_lo_reg} - db14;
        span_sel = pos ? span_p : span_n;
        zero   = dead || (span_sel <= 14'sd0) || (a14 <= 14'sd0);
    end

    always_comb
    begin
        a_lim = (s3_a_reg > s3_span_reg) ? s3_span_reg : s3_a_reg;
        prod  = PROD_W'(a_lim) * PROD_W'(cfg.full_scale);
        if (s3_zero_reg)
        begin
            // force a zero quotient
            s4_next.rem = '0;
            s4_next.dvd = '0;
            s4_next.dvs = CFG_W'(1);
        end
        else
        begin
            s4_next.rem = prod[PROD_W-1:Q_W];
            s4_next.dvd = prod[Q_W-1:0];
            s4_next.dvs = s3_span_reg;
        end
        s4_next.quo  = '0;
        s4_next.neg  = s3_neg_reg;
        s4_next.dead = s3_dead_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            if (ld1) s1_v_reg <= in_valid;
            if (ld2) s2_v_reg <= s1_v_reg;
            if (ld3) s3_v_reg <= s2_v_reg;
            if (ld4) s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_smp_reg <= sample;
            s1_lo_reg  <= s1_lo_next;
            s1_hi_reg  <= s1_hi_next;
        end
        if (ld2)
        begin
            s2_off_reg <= s2_off_next;
            s2_lo_reg  <= s1_lo_reg;
            s2_hi_reg  <= s1_hi_reg;
        end
        if (ld3)
        begin
            s3_a_reg    <= a14[CFG_W-1:0];
            s3_span_reg <= span_sel[CFG_W-1:0];
            s3_neg_reg  <= !pos;
            s3_dead_reg <= dead;
            s3_zero_reg <= zero;
        end
        if (ld4)
            s4_reg <= s4_next;
    end

endmodule

`default_nettype wire

// ----- design/jam_div_cell.sv -----
// One restoring-division cell: produces one quotient bit per transaction.
// Depends on jam_pkg; chained in joystick_axis_mapper_unit.
`default_nettype none

module jam_div_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          up_valid,
    output logic               up_ready,
    input  wire jam_pkg::div_t up_data,
    output logic               dn_valid,
    input  wire logic          dn_ready,
    output jam_pkg::div_t      dn_data
);
    import jam_pkg::*;

    logic             v_reg;
    div_t             data_reg, data_next;
    logic [CFG_W:0]   trial, diff;
    logic             ge;

    assign up_ready = !v_reg || dn_ready;
    assign dn_valid = v_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        trial = {up_data.rem, up_data.dvd[Q_W-1]};
        ge    = trial >= {1'b0, up_data.dvs};
        diff  = trial - {1'b0, up_data.dvs};
        data_next      = up_data;
        data_next.rem  = ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
        data_next.dvd  = {up_data.dvd[Q_W-2:0], 1'b0};
        data_next.quo  = {up_data.quo[Q_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
            data_reg <= data_next;
    end

`ifndef ASSERT_OFF
    a_rem_below_dvs: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg |-> (data_reg.rem < data_reg.dvs))
        else $error("partial remainder not below divisor");

    a_dvs_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg |-> (data_reg.dvs != '0))
        else $error("zero divisor in division cell");
`endif

endmodule

`default_nettype wire

// ----- design/joystick_axis_mapper_unit.sv -----
// Top level of the joystick axis mapper: configuration registers, front pipeline,
// row of jam_div_cell division cells and the output register. Depends on jam_pkg.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+--------------------------------------
//   cfg     | cfg_valid/cfg_ready  | cfg_index[2:0], cfg_data[14:0]
//   in      | in_valid/in_ready    | sample[SAMPLE_BITS-1:0]
//   out     | out_valid/out_ready  | command[15:0] signed, in_dead_zone
//
// Flow: one transaction per cycle sustained while out_ready stays high; a result passes
//   through 4 front stages, 15 division cells and 1 output register, all registered.
//   Most of these stages are the row of division cells, one quotient bit each.
// Reset: clears all valid bits and loads the register defaults; no clearing pass.
// Stalls: ready ripples back stage by stage, so empty stages keep taking input
//   while a result waits at the output. cfg_ready is always high.
`default_nettype none

module joystick_axis_mapper_unit #(
    parameter int SAMPLE_BITS = jam_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [jam_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [jam_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [SAMPLE_BITS-1:0]           sample,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic signed [jam_pkg::CMD_W-1:0]      command,
    output logic                                  in_dead_zone
);
    import jam_pkg::*;

    // configuration registers
    cfg_t cfg_reg;

    // division chain: entry 0 comes from the front, entry Q_W goes to the output
    logic chain_valid [0:Q_W];
    logic chain_ready [0:Q_W];
    div_t chain_data  [0:Q_W];

    // output register
    logic                    out_valid_reg;
    logic signed [CMD_W-1:0] command_reg, command_next;
    logic                    dead_reg;
    logic                    ld_out;
    logic [CMD_W-1:0]        q_ext;

    assign cfg_ready = 1'b1;

    // Decode the register index; drop writes beyond the list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_min    <= RST_RANGE_MIN;
            cfg_reg.range_center <= RST_RANGE_CENTER;
            cfg_reg.range_max    <= RST_RANGE_MAX;
            cfg_reg.dead_width   <= RST_DEAD_WIDTH;
            cfg_reg.margin       <= RST_MARGIN;
            cfg_reg.full_scale   <= RST_FULL_SCALE;
            cfg_reg.reverse      <= RST_REVERSE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RANGE_MIN:    cfg_reg.range_min    <= cfg_data[CFG_W-1:0];
                CFG_RANGE_CENTER: cfg_reg.range_center <= cfg_data[CFG_W-1:0];
                CFG_RANGE_MAX:    cfg_reg.range_max    <= cfg_data[CFG_W-1:0];
                CFG_DEAD_WIDTH:   cfg_reg.dead_width   <= cfg_data[CFG_W-1:0];
                CFG_MARGIN:       cfg_reg.margin       <= cfg_data[CFG_W-1:0];
                CFG_FULL_SCALE:   cfg_reg.full_scale   <= cfg_data[FS_W-1:0];
                CFG_REVERSE:      cfg_reg.reverse      <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Limits, clamp, centering, deadband and the scaling product.
    jam_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sample   (sample),
        .dn_valid (chain_valid[0]),
        .dn_ready (chain_ready[0]),
        .dn_data  (chain_data[0])
    );

    // One cell per quotient bit; each hands its transaction to the next.
    for (genvar k = 0; k < Q_W; k++)
    begin : g_cell
        jam_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[k]),
            .up_ready (chain_ready[k]),
            .up_data  (chain_data[k]),
            .dn_valid (chain_valid[k+1]),
            .dn_ready (chain_ready[k+1]),
            .dn_data  (chain_data[k+1])
        );
    end

    // Apply the side's sign and hold the result until it is taken.
    assign ld_out             = !out_valid_reg || out_ready;
    assign chain_ready[Q_W]   = ld_out;
    assign q_ext              = {1'b0, chain_data[Q_W].quo};
    assign command_next       = chain_data[Q_W].neg ? -q_ext : q_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ld_out)
            out_valid_reg <= chain_valid[Q_W];
    end

    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            command_reg <= command_next;
            dead_reg    <= chain_data[Q_W].dead;
        end
    end

    assign out_valid    = out_valid_reg;
    assign command      = command_reg;
    assign in_dead_zone = dead_reg;

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid_reg && !out_ready))
        else $error("input stalled while the output is free");

    a_dead_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dead_reg) |-> (command_reg == '0))
        else $error("deadband result with nonzero command");
`endif

endmodule

`default_nettype wire
